// ----- hw/rtl/adjacency_bit_matrix_engine_core_macros.svh -----
// Assertion macros for the adjacency bit matrix engine.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef ADJACENCY_BIT_MATRIX_ENGINE_CORE_MACROS_SVH
`define ADJACENCY_BIT_MATRIX_ENGINE_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ABME_HOLDS_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ABME_HOLDS_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/abme_pkg.sv -----
// Shared types, action codes and saturating count helpers for the
// adjacency bit matrix engine. No dependencies.
package abme_pkg;

  typedef logic [2:0]  action_t;
  typedef logic [5:0]  vertex_t;
  typedef logic [6:0]  vcount_t;
  typedef logic [15:0] count_t;

  // Action codes
  localparam action_t ACT_INSERT   = 3'd0;
  localparam action_t ACT_REMOVE   = 3'd1;
  localparam action_t ACT_QUERY    = 3'd2;
  localparam action_t ACT_SYMM     = 3'd3;
  localparam action_t ACT_SETDIR   = 3'd4;
  localparam action_t ACT_COMPLETE = 3'd5;
  localparam action_t ACT_CLEAR    = 3'd6;

  // Configuration register indexes
  localparam logic REG_VCOUNT = 1'b0;
  localparam logic REG_SDIR   = 1'b1;

  localparam vcount_t VCOUNT_RESET = 7'd64;
  localparam count_t  COUNT_MAX    = 16'hFFFF;

  // Columns handled per cycle by the symmetrize walk
  localparam int CHUNK_LOG  = 3;
  localparam int CHUNK_BITS = 1 << CHUNK_LOG;

  // Add, clamping at the top of the count range
  function automatic count_t sat_add(input count_t a, input count_t b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? COUNT_MAX : s[15:0];
  endfunction

  // Subtract one, clamping at zero
  function automatic count_t sat_dec(input count_t a);
    return (a == '0) ? a : a - 16'd1;
  endfunction

endpackage

// ----- hw/rtl/adjacency_bit_matrix_engine_core.sv -----
// Top level of the adjacency bit matrix engine: sequencer, edge count unit,
// configuration registers. Uses abme_pkg, abme_ram and the assertion macros.
//
// Channel | Dir | Handshake             | Payload
// in      | in  | in_valid / in_ready   | in_action, in_from_vertex, in_to_vertex
// out     | out | out_valid / out_ready | out_answer_bit, out_edge_total,
//         |     |                       | out_is_directed, out_range_error
// cfg     | in  | APB-style, pready = 1 | vertex_count at 0x0, start_directed at 0x4
//
// Edge actions read the rows, then do a read-modify-write; an undirected insert
// or remove then updates the mirror bit as a second row update.
// Set directed, clear, range errors and unused codes go straight to the result.
// Symmetrize: each row is read, its columns go 8 per cycle through the shared
// saturating count unit, then it is written.
// Check complete reads one row per cycle through the row memory port.
// Reset clears the row valid flags, so every row reads as zero; no clearing pass.
// in_ready is high only while idle; a finished result waits in the output
// register while the next transfer is taken.
`include "adjacency_bit_matrix_engine_core_macros.svh"

module adjacency_bit_matrix_engine_core #(
  parameter int MAX_VERTICES = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  // Input channel
  input  logic              in_valid,
  output logic              in_ready,
  input  abme_pkg::action_t in_action,
  input  abme_pkg::vertex_t in_from_vertex,
  input  abme_pkg::vertex_t in_to_vertex,
  // Result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_answer_bit,
  output abme_pkg::count_t  out_edge_total,
  output logic              out_is_directed,
  output logic              out_range_error,
  // Configuration port
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [2:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  import abme_pkg::*;

  localparam int RW  = $clog2(MAX_VERTICES);
  localparam int NW  = $clog2(MAX_VERTICES + 1);
  localparam int CW  = (NW > 7) ? NW : 7;
  localparam int NCH = (MAX_VERTICES + CHUNK_BITS - 1) / CHUNK_BITS;
  localparam int KW  = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int PW  = NCH * CHUNK_BITS;
  localparam int JW  = KW + CHUNK_LOG;

  localparam logic [MAX_VERTICES-1:0] ONE_ROW = MAX_VERTICES'(1);
  localparam logic [PW-1:0]           ONE_PAD = PW'(1);

  // Sequencer states
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_EDGE    = 3'd1;
  localparam logic [2:0] ST_EDGE2   = 3'd2;
  localparam logic [2:0] ST_SYM_LD  = 3'd3;
  localparam logic [2:0] ST_SYM_CNT = 3'd4;
  localparam logic [2:0] ST_SYM_WR  = 3'd5;
  localparam logic [2:0] ST_CMP     = 3'd6;
  localparam logic [2:0] ST_DONE    = 3'd7;

  // Control state
  logic [2:0]              state_r, state_nxt;
  logic [RW-1:0]           row_r, row_nxt;
  logic [KW-1:0]           k_r, k_nxt;
  count_t                  count_r, count_nxt;
  logic                    dir_r, dir_nxt;
  vcount_t                 vcount_r, vcount_nxt;
  logic                    sdir_r, sdir_nxt;
  logic [MAX_VERTICES-1:0] rvalid_r, rvalid_nxt;
  logic [MAX_VERTICES-1:0] cvalid_r, cvalid_nxt;
  logic                    out_valid_r, out_valid_nxt;

  // Payload state
  action_t                 act_r, act_nxt;
  logic [RW-1:0]           a_r, a_nxt;
  logic [RW-1:0]           b_r, b_nxt;
  logic [RW-1:0]           rq_r, rq_nxt;
  logic [RW-1:0]           cq_r, cq_nxt;
  logic                    ans_r, ans_nxt;
  logic                    err_r, err_nxt;
  logic [PW-1:0]           rowr_r, rowr_nxt;
  logic [PW-1:0]           rowc_r, rowc_nxt;
  logic                    out_answer_bit_r, out_answer_bit_nxt;
  count_t                  out_edge_total_r, out_edge_total_nxt;
  logic                    out_is_directed_r, out_is_directed_nxt;
  logic                    out_range_error_r, out_range_error_nxt;

  // Row memory (R) and its transpose (C): C[j] bit i mirrors R[i] bit j
  logic                    r_we, r_re, c_we, c_re;
  logic [RW-1:0]           r_waddr, r_raddr, c_waddr, c_raddr;
  logic [MAX_VERTICES-1:0] r_wdata, r_rdata, c_wdata, c_rdata;

  abme_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_row_ram (
    .clk     (clk),
    .wr_en   (r_we),
    .wr_addr (r_waddr),
    .wr_data (r_wdata),
    .rd_en   (r_re),
    .rd_addr (r_raddr),
    .rd_data (r_rdata)
  );

  abme_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_col_ram (
    .clk     (clk),
    .wr_en   (c_we),
    .wr_addr (c_waddr),
    .wr_data (c_wdata),
    .rd_en   (c_re),
    .rd_addr (c_raddr),
    .rd_data (c_rdata)
  );

  // Configuration port
  logic cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_SDIR) ? 32'(sdir_r) : 32'(vcount_r);

  // Effective vertex count, clamped to the matrix size
  logic [CW-1:0] vcount_ext, n_eff, n_last;
  assign vcount_ext = CW'(vcount_r);
  assign n_eff      = (vcount_ext > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : vcount_ext;
  assign n_last     = n_eff - CW'(1);

  // Columns inside the vertices in use
  logic [PW-1:0] ltn_pw;
  always_comb begin
    for (int j = 0; j < PW; j++) begin
      ltn_pw[j] = (CW'(j) < n_eff);
    end
  end

  // Input decode
  logic          in_fire, in_edge_act, in_err;
  logic [CW-1:0] a_in_ext, b_in_ext;
  logic [RW-1:0] a_in_idx, b_in_idx;
  assign in_ready    = (state_r == ST_IDLE);
  assign in_fire     = in_valid & in_ready;
  assign in_edge_act = in_action inside {ACT_INSERT, ACT_REMOVE, ACT_QUERY};
  assign a_in_ext    = CW'(in_from_vertex);
  assign b_in_ext    = CW'(in_to_vertex);
  assign a_in_idx    = a_in_ext[RW-1:0];
  assign b_in_idx    = b_in_ext[RW-1:0];
  assign in_err      = (a_in_ext >= n_eff) || (b_in_ext >= n_eff);

  // Read data, masked by the row valid flags
  logic [MAX_VERTICES-1:0] rdr_row, rdc_row, oh_a, oh_b;
  assign rdr_row = rvalid_r[rq_r] ? r_rdata : '0;
  assign rdc_row = cvalid_r[cq_r] ? c_rdata : '0;
  assign oh_a    = ONE_ROW << a_r;
  assign oh_b    = ONE_ROW << b_r;

  // Symmetrize: one column chunk of the current row
  logic [JW-1:0]         jbase;
  logic [CHUNK_BITS-1:0] ch_r, ch_c;
  logic [3:0]            kinc_lo, kinc_hi;
  logic                  diag_hit, chunk_last;
  assign jbase      = {k_r, {CHUNK_LOG{1'b0}}};
  assign ch_r       = rowr_r[jbase +: CHUNK_BITS];
  assign ch_c       = rowc_r[jbase +: CHUNK_BITS];
  assign chunk_last = (CW'(k_r) == (n_last >> CHUNK_LOG));

  always_comb begin : chunk_calc
    logic [CW-1:0] jt;
    logic          xt;
    kinc_lo  = '0;
    kinc_hi  = '0;
    diag_hit = 1'b0;
    for (int t = 0; t < CHUNK_BITS; t++) begin
      jt = CW'(jbase) + CW'(t);
      xt = ch_r[t] & ~ch_c[t] & (jt < n_eff);
      if (xt && (jt < CW'(row_r))) kinc_lo = kinc_lo + 4'd1;
      if (xt && (jt > CW'(row_r))) kinc_hi = kinc_hi + 4'd1;
      if ((jt == CW'(row_r)) && ch_r[t]) diag_hit = 1'b1;
    end
  end

  // Symmetrize: merged row for write-back, columns outside the range kept
  logic [PW-1:0] ohi_pw, sym_f, rnew_pw, cnew_pw;
  assign ohi_pw  = ONE_PAD << row_r;
  assign sym_f   = (rowr_r | rowc_r) & ~ohi_pw;
  assign rnew_pw = (sym_f & ltn_pw) | (rowr_r & ~ltn_pw);
  assign cnew_pw = (sym_f & ltn_pw) | (rowc_r & ~ltn_pw);

  // Complete check: every in-range column above the diagonal set
  logic [MAX_VERTICES-1:0] cmp_mask;
  logic                    cmp_ok;
  always_comb begin
    for (int j = 0; j < MAX_VERTICES; j++) begin
      cmp_mask[j] = (CW'(j) > CW'(row_r)) && ltn_pw[j];
    end
  end
  assign cmp_ok = &(rdr_row | ~cmp_mask);

  // Shared saturating count unit: add, optional decrement, add
  count_t u_a, u_b, u_s1, u_s2, unit_res;
  logic   u_dec, cnt_en, cnt_clr;
  assign u_s1     = sat_add(count_r, u_a);
  assign u_s2     = u_dec ? sat_dec(u_s1) : u_s1;
  assign unit_res = sat_add(u_s2, u_b);

  logic out_free;
  assign out_free = !out_valid_r || out_ready;

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    row_nxt    = row_r;
    k_nxt      = k_r;
    dir_nxt    = dir_r;
    vcount_nxt = vcount_r;
    sdir_nxt   = sdir_r;
    rvalid_nxt = rvalid_r;
    cvalid_nxt = cvalid_r;
    act_nxt    = act_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    rq_nxt     = rq_r;
    cq_nxt     = cq_r;
    ans_nxt    = ans_r;
    err_nxt    = err_r;
    rowr_nxt   = rowr_r;
    rowc_nxt   = rowc_r;
    out_answer_bit_nxt  = out_answer_bit_r;
    out_edge_total_nxt  = out_edge_total_r;
    out_is_directed_nxt = out_is_directed_r;
    out_range_error_nxt = out_range_error_r;
    out_valid_nxt       = out_valid_r && !out_ready;
    r_we = 1'b0; r_waddr = '0; r_wdata = '0; r_re = 1'b0; r_raddr = '0;
    c_we = 1'b0; c_waddr = '0; c_wdata = '0; c_re = 1'b0; c_raddr = '0;
    u_a = '0; u_b = '0; u_dec = 1'b0; cnt_en = 1'b0; cnt_clr = 1'b0;

    // Register writes
    if (cfg_wr) begin
      if (cfg_paddr[2] == REG_VCOUNT) begin
        vcount_nxt = cfg_pwdata[6:0];
      end else begin
        sdir_nxt = cfg_pwdata[0];
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          act_nxt = in_action;
          a_nxt   = a_in_idx;
          b_nxt   = b_in_idx;
          ans_nxt = 1'b0;
          err_nxt = 1'b0;
          row_nxt = '0;
          if (in_edge_act) begin
            if (in_err) begin
              err_nxt   = 1'b1;
              state_nxt = ST_DONE;
            end else begin
              r_re = 1'b1; r_raddr = a_in_idx; rq_nxt = a_in_idx;
              c_re = 1'b1; c_raddr = b_in_idx; cq_nxt = b_in_idx;
              state_nxt = ST_EDGE;
            end
          end else begin
            state_nxt = ST_DONE;
            case (in_action)
              ACT_SYMM: begin
                if (n_eff == '0) begin
                  dir_nxt = 1'b0;
                end else begin
                  r_re = 1'b1; rq_nxt = '0;
                  c_re = 1'b1; cq_nxt = '0;
                  state_nxt = ST_SYM_LD;
                end
              end
              ACT_SETDIR: begin
                dir_nxt = 1'b1;
                u_a     = count_r;
                cnt_en  = 1'b1;
              end
              ACT_COMPLETE: begin
                if (!dir_r) begin
                  ans_nxt = 1'b1;
                  if (n_eff != '0) begin
                    r_re = 1'b1; rq_nxt = '0;
                    state_nxt = ST_CMP;
                  end
                end
              end
              ACT_CLEAR: begin
                rvalid_nxt = '0;
                cvalid_nxt = '0;
                cnt_clr    = 1'b1;
                dir_nxt    = sdir_r;
              end
              default: begin
              end
            endcase
          end
        end
      end

      // First row update: R[a] and C[b]
      ST_EDGE: begin
        state_nxt = ST_DONE;
        case (act_r)
          ACT_INSERT: begin
            if (!rdr_row[b_r] && (dir_r || (a_r != b_r))) begin
              r_we = 1'b1; r_waddr = a_r; r_wdata = rdr_row | oh_b;
              c_we = 1'b1; c_waddr = b_r; c_wdata = rdc_row | oh_a;
              u_a = 16'd1; cnt_en = 1'b1;
              if (!dir_r) begin
                r_re = 1'b1; r_raddr = b_r; rq_nxt = b_r;
                c_re = 1'b1; c_raddr = a_r; cq_nxt = a_r;
                state_nxt = ST_EDGE2;
              end
            end
          end
          ACT_REMOVE: begin
            if (rdr_row[b_r]) begin
              r_we = 1'b1; r_waddr = a_r; r_wdata = rdr_row & ~oh_b;
              c_we = 1'b1; c_waddr = b_r; c_wdata = rdc_row & ~oh_a;
              u_dec = 1'b1; cnt_en = 1'b1;
              if (!dir_r && (a_r != b_r)) begin
                r_re = 1'b1; r_raddr = b_r; rq_nxt = b_r;
                c_re = 1'b1; c_raddr = a_r; cq_nxt = a_r;
                state_nxt = ST_EDGE2;
              end
            end
          end
          ACT_QUERY: begin
            ans_nxt = rdr_row[b_r];
          end
          default: begin
          end
        endcase
      end

      // Mirror bit of an undirected edge: R[b] and C[a]
      ST_EDGE2: begin
        r_we = 1'b1; r_waddr = b_r;
        c_we = 1'b1; c_waddr = a_r;
        if (act_r == ACT_INSERT) begin
          r_wdata = rdr_row | oh_a;
          c_wdata = rdc_row | oh_b;
        end else begin
          r_wdata = rdr_row & ~oh_a;
          c_wdata = rdc_row & ~oh_b;
        end
        state_nxt = ST_DONE;
      end

      // Hold row i and column i for the chunk walk
      ST_SYM_LD: begin
        rowr_nxt  = PW'(rdr_row);
        rowc_nxt  = PW'(rdc_row);
        k_nxt     = '0;
        state_nxt = ST_SYM_CNT;
      end

      // Count one-way edges below the diagonal, the self-loop, then above
      ST_SYM_CNT: begin
        u_a    = count_t'(kinc_lo);
        u_dec  = diag_hit;
        u_b    = count_t'(kinc_hi);
        cnt_en = 1'b1;
        if (chunk_last) begin
          state_nxt = ST_SYM_WR;
        end else begin
          k_nxt = k_r + KW'(1);
        end
      end

      // Write merged row to both copies, fetch the next row
      ST_SYM_WR: begin
        r_we = 1'b1; r_waddr = row_r; r_wdata = rnew_pw[MAX_VERTICES-1:0];
        c_we = 1'b1; c_waddr = row_r; c_wdata = cnew_pw[MAX_VERTICES-1:0];
        if (CW'(row_r) == n_last) begin
          dir_nxt   = 1'b0;
          state_nxt = ST_DONE;
        end else begin
          row_nxt = row_r + RW'(1);
          r_re = 1'b1; r_raddr = row_r + RW'(1); rq_nxt = row_r + RW'(1);
          c_re = 1'b1; c_raddr = row_r + RW'(1); cq_nxt = row_r + RW'(1);
          state_nxt = ST_SYM_LD;
        end
      end

      // One row per cycle; stop at the first gap
      ST_CMP: begin
        if (!cmp_ok) begin
          ans_nxt   = 1'b0;
          state_nxt = ST_DONE;
        end else if (CW'(row_r) == n_last) begin
          state_nxt = ST_DONE;
        end else begin
          row_nxt = row_r + RW'(1);
          r_re = 1'b1; r_raddr = row_r + RW'(1); rq_nxt = row_r + RW'(1);
        end
      end

      // Load the result once the output register is free
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt       = 1'b1;
          out_answer_bit_nxt  = ans_r;
          out_edge_total_nxt  = count_r;
          out_is_directed_nxt = dir_r;
          out_range_error_nxt = err_r;
          state_nxt           = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Mark written rows valid
    if (r_we) rvalid_nxt[r_waddr] = 1'b1;
    if (c_we) cvalid_nxt[c_waddr] = 1'b1;

    // Edge count
    if (cnt_clr) begin
      count_nxt = '0;
    end else if (cnt_en) begin
      count_nxt = unit_res;
    end else begin
      count_nxt = count_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row_r       <= '0;
      k_r         <= '0;
      count_r     <= '0;
      dir_r       <= 1'b0;
      vcount_r    <= VCOUNT_RESET;
      sdir_r      <= 1'b0;
      rvalid_r    <= '0;
      cvalid_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      k_r         <= k_nxt;
      count_r     <= count_nxt;
      dir_r       <= dir_nxt;
      vcount_r    <= vcount_nxt;
      sdir_r      <= sdir_nxt;
      rvalid_r    <= rvalid_nxt;
      cvalid_r    <= cvalid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    act_r             <= act_nxt;
    a_r               <= a_nxt;
    b_r               <= b_nxt;
    rq_r              <= rq_nxt;
    cq_r              <= cq_nxt;
    ans_r             <= ans_nxt;
    err_r             <= err_nxt;
    rowr_r            <= rowr_nxt;
    rowc_r            <= rowc_nxt;
    out_answer_bit_r  <= out_answer_bit_nxt;
    out_edge_total_r  <= out_edge_total_nxt;
    out_is_directed_r <= out_is_directed_nxt;
    out_range_error_r <= out_range_error_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_answer_bit  = out_answer_bit_r;
  assign out_edge_total  = out_edge_total_r;
  assign out_is_directed = out_is_directed_r;
  assign out_range_error = out_range_error_r;

  // Checks
  `ABME_HOLDS_NEXT(a_idle_count_hold, (state_r == ST_IDLE) && !in_fire, count_r == $past(count_r), "edge count moved while idle")
  `ABME_HOLDS_NEXT(a_clear_empties, in_fire && (in_action == ACT_CLEAR), (rvalid_r == '0) && (cvalid_r == '0) && (count_r == '0), "clear left rows or count behind")
  `ABME_HOLDS_NOW(a_mirror_undirected, state_r == ST_EDGE2, !dir_r && (a_r != b_r) && ((act_r == ACT_INSERT) || (act_r == ACT_REMOVE)), "mirror update outside an undirected edge change")
  `ABME_HOLDS_NEXT(a_done_delivers, (state_r == ST_DONE) && out_free, out_valid_r && (state_r == ST_IDLE), "finished result not loaded")

endmodule

// ----- hw/rtl/abme_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module abme_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
